@@ rtl/dcmf_pkg.sv @@
package dcmf_pkg;

    localparam int DATA_W     = 8;
    localparam int ROW_W      = 12;
    localparam int COL_OUT_W  = 11;
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 13;
    localparam int RAD_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [DATA_W-1:0] DARK_MAX = 8'hFF;

    // Command word broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic init;
        logic rd;
        logic acc;
        logic shift;
    } cell_cmd_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_ROWS  = 6'b000100,
        ST_LAST  = 6'b001000,
        ST_FOLD  = 6'b010000,
        ST_OUT   = 6'b100000
    } seq_state_t;

endpackage

@@ rtl/dcmf_cell.sv @@
module dcmf_cell #(
    parameter int IDX   = 0,
    parameter int N     = 15,
    parameter int RM    = 7,
    parameter int CW    = 11,
    parameter int BW    = 4,
    parameter int WDW   = 8,
    parameter int AW    = 11,
    parameter int DEPTH = 2055
) (
    input  logic                          aclk,
    input  dcmf_pkg::cell_cmd_t           cmd,
    input  logic [CW-1:0]                 emit_col,
    input  logic [BW-1:0]                 ebank,
    input  logic [WDW-1:0]                eword,
    input  logic [dcmf_pkg::RAD_W-1:0]    r_eff,
    input  logic [CW-1:0]                 w_last,
    input  logic [AW-1:0]                 rd_base,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [dcmf_pkg::DATA_W-1:0]   wr_data,
    input  logic [dcmf_pkg::DATA_W-1:0]   acc_in,
    output logic [dcmf_pkg::DATA_W-1:0]   acc_out
);

    localparam int KW = BW + 2;
    localparam int XW = ((CW > BW) ? CW : BW) + 2;
    localparam logic signed [KW-1:0] IDX_S = KW'(IDX);
    localparam logic signed [KW-1:0] N_S   = KW'(N);
    localparam logic signed [KW-1:0] RM_S  = KW'(RM);
    localparam logic signed [XW-1:0] N_X   = XW'(N);

    // This cell owns the bank of columns congruent to IDX modulo N.
    logic [dcmf_pkg::DATA_W-1:0] mem [DEPTH];

    logic [dcmf_pkg::DATA_W-1:0] rdata_reg;
    logic [dcmf_pkg::DATA_W-1:0] acc_reg;
    logic                        use_reg;
    logic [WDW-1:0]              word_reg;

    logic signed [KW-1:0] kdiff;
    logic signed [KW-1:0] kmod;
    logic signed [KW-1:0] delta;
    logic signed [KW-1:0] absd;
    logic signed [XW-1:0] delta_x;
    logic signed [XW-1:0] col_x;
    logic signed [XW-1:0] bsum;
    logic                 use_next;
    logic [WDW-1:0]       word_next;
    logic [AW-1:0]        rd_addr;

    always_comb begin
        kdiff   = IDX_S - $signed({2'b00, ebank});
        kmod    = (kdiff < 0) ? kdiff + N_S : kdiff;
        delta   = (kmod > RM_S) ? kmod - N_S : kmod;
        absd    = (delta < 0) ? -delta : delta;
        delta_x = XW'(delta);
        col_x   = $signed(XW'(emit_col)) + delta_x;
        bsum    = $signed(XW'(ebank)) + delta_x;
        use_next = (absd <= $signed(KW'(r_eff))) && (col_x >= 0)
                   && (col_x <= $signed(XW'(w_last)));
        if (bsum >= N_X) begin
            word_next = eword + WDW'(1);
        end else if (bsum < 0) begin
            word_next = eword - WDW'(1);
        end else begin
            word_next = eword;
        end
        rd_addr = rd_base + AW'(word_reg);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            acc_reg  <= dcmf_pkg::DARK_MAX;
            use_reg  <= use_next;
            word_reg <= word_next;
        end else if (cmd.acc) begin
            if (use_reg && (rdata_reg < acc_reg)) begin
                acc_reg <= rdata_reg;
            end
        end else if (cmd.shift) begin
            acc_reg <= acc_in;
        end
    end

    assign acc_out = acc_reg;

endmodule

@@ rtl/dark_channel_min_filter_top.sv @@
// Dark-channel minimum filter. Each pixel word (s_tuser = 0) is reduced to the minimum of
// its three samples and written to a line store split into 2*MAX_RADIUS+1 column banks, one
// per cell of a chain. The store keeps 2r+2 image rows when they fit and 2r+1 otherwise.
// A result for a pixel is the minimum over its border-clipped square
// window and appears r rows plus r pixels after that pixel went in; flush words
// (s_tuser = 1) drain the results still pending after the last pixel. A word that produces
// no result leaves s_tready high; one that produces a result holds it low until that result
// is offered on the output, which can stall on m_tready. Its window rows inside the image
// (at most 2r+1) are read in turn, each as one read of all banks in parallel, and the column
// minima held by the cells are then shifted along the chain into the result, one cell a
// cycle. Configuration writes restart the positions and the pending count; the store needs
// no clearing after reset.
module dark_channel_min_filter_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 7
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dcmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dcmf_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dcmf_pkg::S_TDATA_W-1:0]      s_tdata,   // blue, green, red
    input  logic                                s_tuser,   // opcode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dcmf_pkg::M_TDATA_W-1:0]      m_tdata,   // dark, out_row, out_col, pad
    output logic                                m_tlast    // last_of_frame
);

    localparam int N     = 2 * MAX_RADIUS + 1;
    localparam int BW    = $clog2(N);
    localparam int WPB   = (MAX_WIDTH + N - 1) / N;
    localparam int WDW   = (WPB > 1) ? $clog2(WPB) : 1;
    localparam int DEPTH = (N + 1) * WPB;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int PW    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
    localparam int RW    = dcmf_pkg::ROW_W;
    localparam int DW    = dcmf_pkg::DATA_W;
    localparam int CNTW  = dcmf_pkg::RAD_W + 1;
    localparam int FW    = dcmf_pkg::RAD_W + 2 + WW;

    localparam logic [AW-1:0] WPB_A  = AW'(WPB);
    localparam logic [BW-1:0] BANK_L = BW'(N - 1);
    localparam logic [FW-1:0] STORE_WORDS = FW'(MAX_WIDTH * N);

    // Configuration registers.
    logic [dcmf_pkg::IMG_W_W-1:0] img_w_reg;
    logic [dcmf_pkg::IMG_H_W-1:0] img_h_reg;
    logic [dcmf_pkg::RAD_W-1:0]   rad_reg;

    logic [WW-1:0]                w_eff;
    logic [CW-1:0]                w_last;
    logic [RW-1:0]                h_last;
    logic [dcmf_pkg::RAD_W-1:0]   r_eff;
    logic [BW-1:0]                s_last;
    logic [PW-1:0]                thr;
    logic                         slots_fit;

    always_comb begin
        if (img_w_reg == '0) begin
            w_eff = WW'(1);
        end else if (int'(img_w_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(img_w_reg);
        end
        w_last = CW'(w_eff - WW'(1));
        if (img_h_reg == '0) begin
            h_last = '0;
        end else if (int'(img_h_reg) > dcmf_pkg::MAX_HEIGHT) begin
            h_last = RW'(dcmf_pkg::MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(img_h_reg - dcmf_pkg::IMG_H_W'(1));
        end
        r_eff  = (int'(rad_reg) > MAX_RADIUS) ? dcmf_pkg::RAD_W'(MAX_RADIUS) : rad_reg;
        // One spare row slot is kept whenever 2r+2 full rows fit in the store.
        slots_fit = ((FW'({r_eff, 1'b0}) + FW'(2)) * FW'(w_eff)) <= STORE_WORDS;
        s_last = slots_fit ? BW'({r_eff, 1'b1}) : BW'({r_eff, 1'b0});
        thr    = PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
    end

    // Sequencer and position state.
    dcmf_pkg::seq_state_t state_reg, state_next;

    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [BW-1:0]  in_bank_reg, in_bank_next;
    logic [WDW-1:0] in_word_reg, in_word_next;
    logic [RW-1:0]  in_row_reg, in_row_next;
    logic [BW-1:0]  wr_slot_reg, wr_slot_next;
    logic [AW-1:0]  wr_base_reg, wr_base_next;

    logic [CW-1:0]  emit_col_reg, emit_col_next;
    logic [BW-1:0]  ebank_reg, ebank_next;
    logic [WDW-1:0] eword_reg, eword_next;
    logic [RW-1:0]  emit_row_reg, emit_row_next;
    logic [BW-1:0]  rd_slot_reg, rd_slot_next;

    logic [PW-1:0]  pending_reg, pending_next;

    logic [BW-1:0]   it_slot_reg, it_slot_next;
    logic [AW-1:0]   it_base_reg, it_base_next;
    logic [CNTW-1:0] row_left_reg, row_left_next;
    logic [BW-1:0]   fold_cnt_reg, fold_cnt_next;
    logic            rvalid_reg;
    logic [DW-1:0]   res_reg, res_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [dcmf_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tlast_reg, m_tlast_next;

    dcmf_pkg::cell_cmd_t cmd;
    logic [DW-1:0] chain [N+1];

    logic            s_acc;
    logic            cfg_hit;
    logic [DW-1:0]   pix_min;
    logic [PW-1:0]   pending_inc;
    logic [RW-1:0]   dist_down_full;
    logic [CNTW-1:0] dist_up;
    logic [CNTW-1:0] dist_down;
    logic [BW:0]     start_slot_w;
    logic [BW-1:0]   start_slot;
    logic            out_free;
    logic            emit_last;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == dcmf_pkg::ST_IDLE);
    assign cfg_hit  = cfg_wr_en && ((cfg_index == dcmf_pkg::CFG_IMAGE_WIDTH)
                      || (cfg_index == dcmf_pkg::CFG_IMAGE_HEIGHT)
                      || (cfg_index == dcmf_pkg::CFG_WINDOW_RADIUS));
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        pix_min = s_tdata[7:0];
        if (s_tdata[15:8] < pix_min) begin
            pix_min = s_tdata[15:8];
        end
        if (s_tdata[23:16] < pix_min) begin
            pix_min = s_tdata[23:16];
        end
    end

    assign cmd.init  = (state_reg == dcmf_pkg::ST_SETUP);
    assign cmd.rd    = (state_reg == dcmf_pkg::ST_ROWS);
    assign cmd.acc   = rvalid_reg;
    assign cmd.shift = (state_reg == dcmf_pkg::ST_FOLD);

    assign chain[N] = dcmf_pkg::DARK_MAX;

    for (genvar i = 0; i < N; i++) begin : g_cell
        dcmf_cell #(
            .IDX  (i),
            .N    (N),
            .RM   (MAX_RADIUS),
            .CW   (CW),
            .BW   (BW),
            .WDW  (WDW),
            .AW   (AW),
            .DEPTH(DEPTH)
        ) u_cell (
            .aclk    (aclk),
            .cmd     (cmd),
            .emit_col(emit_col_reg),
            .ebank   (ebank_reg),
            .eword   (eword_reg),
            .r_eff   (r_eff),
            .w_last  (w_last),
            .rd_base (it_base_reg),
            .wr_en   (s_acc && (s_tuser == dcmf_pkg::OP_PIXEL) && (in_bank_reg == BW'(i))),
            .wr_addr (wr_base_reg + AW'(in_word_reg)),
            .wr_data (pix_min),
            .acc_in  (chain[i+1]),
            .acc_out (chain[i])
        );
    end

    always_comb begin
        // Window rows above and below the emit row that lie inside the image.
        dist_up = (emit_row_reg >= RW'(r_eff)) ? CNTW'(r_eff) : CNTW'(emit_row_reg);
        dist_down_full = h_last - emit_row_reg;
        dist_down = (dist_down_full >= RW'(r_eff)) ? CNTW'(r_eff) : CNTW'(dist_down_full);
        start_slot_w = {1'b0, rd_slot_reg} - (BW + 1)'(dist_up);
        if (rd_slot_reg < BW'(dist_up)) begin
            start_slot_w = start_slot_w + (BW + 1)'(s_last) + (BW + 1)'(1);
        end
        start_slot = BW'(start_slot_w);
        pending_inc = pending_reg + PW'(1);
        emit_last = (emit_row_reg == h_last) && (emit_col_reg == w_last);
    end

    always_comb begin
        state_next    = state_reg;
        in_col_next   = in_col_reg;
        in_bank_next  = in_bank_reg;
        in_word_next  = in_word_reg;
        in_row_next   = in_row_reg;
        wr_slot_next  = wr_slot_reg;
        wr_base_next  = wr_base_reg;
        emit_col_next = emit_col_reg;
        ebank_next    = ebank_reg;
        eword_next    = eword_reg;
        emit_row_next = emit_row_reg;
        rd_slot_next  = rd_slot_reg;
        pending_next  = pending_reg;
        it_slot_next  = it_slot_reg;
        it_base_next  = it_base_reg;
        row_left_next = row_left_reg;
        fold_cnt_next = fold_cnt_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            dcmf_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser == dcmf_pkg::OP_PIXEL) begin
                        if (in_col_reg == w_last) begin
                            in_col_next  = '0;
                            in_bank_next = '0;
                            in_word_next = '0;
                            if (wr_slot_reg == s_last) begin
                                wr_slot_next = '0;
                                wr_base_next = '0;
                            end else begin
                                wr_slot_next = wr_slot_reg + BW'(1);
                                wr_base_next = wr_base_reg + WPB_A;
                            end
                            in_row_next = (in_row_reg == h_last) ? '0 : in_row_reg + RW'(1);
                        end else begin
                            in_col_next = in_col_reg + CW'(1);
                            if (in_bank_reg == BANK_L) begin
                                in_bank_next = '0;
                                in_word_next = in_word_reg + WDW'(1);
                            end else begin
                                in_bank_next = in_bank_reg + BW'(1);
                            end
                        end
                        pending_next = pending_inc;
                        if (pending_inc > thr) begin
                            state_next = dcmf_pkg::ST_SETUP;
                        end
                    end else if (pending_reg != '0) begin
                        state_next = dcmf_pkg::ST_SETUP;
                    end
                end
            end
            dcmf_pkg::ST_SETUP: begin
                it_slot_next  = start_slot;
                it_base_next  = AW'(start_slot) * WPB_A;
                row_left_next = dist_up + dist_down;
                res_next      = dcmf_pkg::DARK_MAX;
                state_next    = dcmf_pkg::ST_ROWS;
            end
            dcmf_pkg::ST_ROWS: begin
                if (it_slot_reg == s_last) begin
                    it_slot_next = '0;
                    it_base_next = '0;
                end else begin
                    it_slot_next = it_slot_reg + BW'(1);
                    it_base_next = it_base_reg + WPB_A;
                end
                row_left_next = row_left_reg - CNTW'(1);
                if (row_left_reg == '0) begin
                    state_next = dcmf_pkg::ST_LAST;
                end
            end
            dcmf_pkg::ST_LAST: begin
                fold_cnt_next = BANK_L;
                state_next    = dcmf_pkg::ST_FOLD;
            end
            dcmf_pkg::ST_FOLD: begin
                if (chain[0] < res_reg) begin
                    res_next = chain[0];
                end
                fold_cnt_next = fold_cnt_reg - BW'(1);
                if (fold_cnt_reg == '0) begin
                    state_next = dcmf_pkg::ST_OUT;
                end
            end
            dcmf_pkg::ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, dcmf_pkg::COL_OUT_W'(emit_col_reg),
                                     emit_row_reg, res_reg};
                    m_tlast_next  = emit_last;
                    if (emit_col_reg == w_last) begin
                        emit_col_next = '0;
                        ebank_next    = '0;
                        eword_next    = '0;
                        rd_slot_next  = (rd_slot_reg == s_last) ? '0 : rd_slot_reg + BW'(1);
                        emit_row_next = (emit_row_reg == h_last) ? '0
                                        : emit_row_reg + RW'(1);
                    end else begin
                        emit_col_next = emit_col_reg + CW'(1);
                        if (ebank_reg == BANK_L) begin
                            ebank_next = '0;
                            eword_next = eword_reg + WDW'(1);
                        end else begin
                            ebank_next = ebank_reg + BW'(1);
                        end
                    end
                    pending_next = pending_reg - PW'(1);
                    state_next   = dcmf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dcmf_pkg::ST_IDLE;
            end
        endcase

        // Cfg writes reset all positions; user must send them only in idle; unenforced.
        if (cfg_hit) begin
            in_col_next   = '0;
            in_bank_next  = '0;
            in_word_next  = '0;
            in_row_next   = '0;
            wr_slot_next  = '0;
            wr_base_next  = '0;
            emit_col_next = '0;
            ebank_next    = '0;
            eword_next    = '0;
            emit_row_next = '0;
            rd_slot_next  = '0;
            pending_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg <= dcmf_pkg::IMG_W_W'(640);
            img_h_reg <= dcmf_pkg::IMG_H_W'(480);
            rad_reg   <= dcmf_pkg::RAD_W'(7);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dcmf_pkg::CFG_IMAGE_WIDTH: begin
                    img_w_reg <= cfg_wr_data[dcmf_pkg::IMG_W_W-1:0];
                end
                dcmf_pkg::CFG_IMAGE_HEIGHT: begin
                    img_h_reg <= cfg_wr_data;
                end
                dcmf_pkg::CFG_WINDOW_RADIUS: begin
                    rad_reg <= cfg_wr_data[dcmf_pkg::RAD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dcmf_pkg::ST_IDLE;
            in_col_reg   <= '0;
            in_bank_reg  <= '0;
            in_word_reg  <= '0;
            in_row_reg   <= '0;
            wr_slot_reg  <= '0;
            wr_base_reg  <= '0;
            emit_col_reg <= '0;
            ebank_reg    <= '0;
            eword_reg    <= '0;
            emit_row_reg <= '0;
            rd_slot_reg  <= '0;
            pending_reg  <= '0;
            rvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_bank_reg  <= in_bank_next;
            in_word_reg  <= in_word_next;
            in_row_reg   <= in_row_next;
            wr_slot_reg  <= wr_slot_next;
            wr_base_reg  <= wr_base_next;
            emit_col_reg <= emit_col_next;
            ebank_reg    <= ebank_next;
            eword_reg    <= eword_next;
            emit_row_reg <= emit_row_next;
            rd_slot_reg  <= rd_slot_next;
            pending_reg  <= pending_next;
            rvalid_reg   <= cmd.rd;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        it_slot_reg  <= it_slot_next;
        it_base_reg  <= it_base_next;
        row_left_reg <= row_left_next;
        fold_cnt_reg <= fold_cnt_next;
        res_reg      <= res_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
